### rtl/smq_pkg.sv
package smq_pkg;

  typedef struct packed {
    logic signed [31:0] col0_x;
    logic signed [31:0] col0_y;
    logic signed [31:0] col0_z;
    logic signed [31:0] col1_x;
    logic signed [31:0] col1_y;
    logic signed [31:0] col1_z;
    logic signed [31:0] col2_x;
    logic signed [31:0] col2_y;
    logic signed [31:0] col2_z;
  } smq_in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } smq_out_t;

  localparam int QBITS = 30;
  localparam logic signed [35:0] QONE = 36'sd1073741824;

endpackage

### rtl/smq_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module smq_isqrt #(
  parameter int IN_W = 66,
  parameter int TAG_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [IN_W-1:0]        radicand,
  input  logic [TAG_W-1:0]       in_tag,
  output logic                   out_valid,
  output logic [(IN_W+1)/2-1:0]  root,
  output logic [TAG_W-1:0]       out_tag
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int PW = 2 * RW;

  logic [RW:0]     vld;
  logic [PW-1:0]   rem [RW+1];
  logic [RW-1:0]   res [RW+1];
  logic [PW-1:0]   rad [RW+1];
  logic [TAG_W-1:0] tag [RW+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = '0;
    res[0] = '0;
    rad[0] = PW'(radicand);
    tag[0] = in_tag;
  end

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [PW-1:0] rem_sh;
    logic          take;
    assign rem_sh = {rem[i][PW-3:0], rad[i][PW-1:PW-2]};
    assign take   = rem_sh >= PW'({res[i], 2'b01});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1] <= {rad[i][PW-3:0], 2'b00};
        rem[i+1] <= take ? rem_sh - PW'({res[i], 2'b01}) : rem_sh;
        res[i+1] <= {res[i][RW-2:0], take};
        tag[i+1] <= tag[i];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = res[RW];
  assign out_tag   = tag[RW];
endmodule

### rtl/smq_div.sv
// Pipelined restoring divider: quotient = (|num| << 30) / den, signed result.
module smq_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 34,
  parameter int Q_W = 36,
  parameter int TAG_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [NUM_W-1:0]         mag,
  input  logic                     neg,
  input  logic [DEN_W-1:0]         den,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     out_valid,
  output logic signed [Q_W:0]      quot,
  output logic [TAG_W-1:0]         out_tag
);
  import smq_pkg::*;
  localparam int DW = NUM_W + QBITS;

  logic [Q_W:0]       vld;
  logic [DW-1:0]      dvd [Q_W+1];
  logic [DEN_W:0]     rem [Q_W+1];
  logic [Q_W-1:0]     q   [Q_W+1];
  logic [DEN_W-1:0]   d   [Q_W+1];
  logic               sg  [Q_W+1];
  logic [TAG_W-1:0]   tag [Q_W+1];

  always_comb begin
    vld[0] = in_valid;
    q[0]   = '0;
    d[0]   = den;
    sg[0]  = neg;
    tag[0] = in_tag;
    // The dividend bits above the quotient width seed the remainder; they stay
    // below den because the quotient fits in Q_W bits.
    rem[0] = (DEN_W+1)'({mag, {QBITS{1'b0}}} >> Q_W);
    dvd[0] = {mag, {QBITS{1'b0}}} << (DW - Q_W);
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W+1:0] sh;
    logic             take;
    assign sh   = {rem[i], dvd[i][DW-1]};
    assign take = sh >= (DEN_W+2)'(d[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dvd[i+1] <= {dvd[i][DW-2:0], 1'b0};
        rem[i+1] <= take ? (DEN_W+1)'(sh - (DEN_W+2)'(d[i])) : (DEN_W+1)'(sh);
        q[i+1]   <= {q[i][Q_W-2:0], take};
        d[i+1]   <= d[i];
        sg[i+1]  <= sg[i];
        tag[i+1] <= tag[i];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot = sg[Q_W] ? -$signed({1'b0, q[Q_W]}) : $signed({1'b0, q[Q_W]});
  assign out_tag = tag[Q_W];
endmodule

### rtl/scaled_matrix_to_quaternion.sv
// The bit-per-stage square root and divider pipelines run in series, with five plain
// register stages besides.
// Throughput: one request per cycle; a stall on the output freezes the whole pipeline
// and the input stall follows the output stall.
// Reset clears only the valid bits; no other state is kept.
module scaled_matrix_to_quaternion #(
  parameter int IN_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smq_pkg::smq_in_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output smq_pkg::smq_out_t   out_data
);
  import smq_pkg::*;

  // The input scale cancels in the column division; the parameter only documents format.
  localparam int FRAC_UNUSED = IN_FRAC_BITS - IN_FRAC_BITS;

  logic en;
  logic [31:0] col [9];
  logic signed [36:0] r [9];
  logic [65:0] ss [3];
  logic [2:0] sv;
  logic [32:0] ln [3];
  logic [8:0] rv;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    col[0] = in_data.col0_x; col[1] = in_data.col0_y; col[2] = in_data.col0_z;
    col[3] = in_data.col1_x; col[4] = in_data.col1_y; col[5] = in_data.col1_z;
    col[6] = in_data.col2_x; col[7] = in_data.col2_y; col[8] = in_data.col2_z;
  end

  // Stage A: sum of squares per column, then square root.
  logic [32:0] mg [9];
  logic [287:0] raw_d;
  logic         va;
  for (genvar i = 0; i < 9; i++) begin : g_mag
    assign mg[i] = col[i][31] ? 33'(-$signed({col[i][31], col[i]})) : {1'b0, col[i]};
  end
  logic [65:0] sq [9];
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) sq[i] <= 66'(mg[i] * mg[i]);
      raw_d <= {col[0], col[1], col[2], col[3], col[4], col[5], col[6], col[7], col[8]};
    end
  end
  logic vb;
  logic [287:0] raw_b;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) ss[c] <= sq[3*c] + sq[3*c+1] + sq[3*c+2];
      raw_b <= raw_d;
    end
  end

  logic [287:0] raw_c [3];
  for (genvar c = 0; c < 3; c++) begin : g_len
    if (c == 0) begin : g_t
      smq_isqrt #(.IN_W(66), .TAG_W(288)) u_sq (
        .clk, .rst, .en, .in_valid(vb), .radicand(ss[c]), .in_tag(raw_b),
        .out_valid(sv[c]), .root(ln[c]), .out_tag(raw_c[c]));
    end else begin : g_n
      smq_isqrt #(.IN_W(66), .TAG_W(1)) u_sq (
        .clk, .rst, .en, .in_valid(vb), .radicand(ss[c]), .in_tag(1'b0),
        .out_valid(sv[c]), .root(ln[c]), .out_tag());
      assign raw_c[c] = '0;
    end
  end

  // Nine dividers for the normalized elements.
  for (genvar i = 0; i < 9; i++) begin : g_rdiv
    logic [31:0] e;
    logic [32:0] em;
    logic [33:0] dn;
    assign e  = raw_c[0][287-32*i -: 32];
    assign em = e[31] ? 33'(-$signed({e[31], e})) : {1'b0, e};
    assign dn = (ln[i/3] == '0) ? 34'd1 : {1'b0, ln[i/3]};
    smq_div #(.NUM_W(33), .DEN_W(34), .Q_W(36), .TAG_W(1)) u_dv (
      .clk, .rst, .en, .in_valid(sv[0]), .mag(em), .neg(e[31]), .den(dn),
      .in_tag(1'b0), .out_valid(rv[i]), .quot(r[i]), .out_tag());
  end

  // Branch selection (rows: r00=r[0], r10=r[1], r20=r[2], r01=r[3] ...).
  logic signed [36:0] r00, r10, r20, r01, r11, r21, r02, r12, r22;
  assign {r00, r10, r20, r01, r11, r21, r02, r12, r22} =
    {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};
  logic signed [38:0] t;
  assign t = r00 + r11 + r22;

  logic        vc;
  logic [1:0]  mi;
  logic signed [38:0] vv;
  logic signed [38:0] qo [4];
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= rv[0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (t > 0) begin
        mi <= 2'd0; vv <= 39'(QONE) + t;
        qo[0] <= '0; qo[1] <= r21 - r12; qo[2] <= r02 - r20; qo[3] <= r10 - r01;
      end else if (r00 > r11 && r00 > r22) begin
        mi <= 2'd1; vv <= 39'(QONE) + r00 - r11 - r22;
        qo[1] <= '0; qo[0] <= r21 - r12; qo[2] <= r01 + r10; qo[3] <= r02 + r20;
      end else if (r11 > r22) begin
        mi <= 2'd2; vv <= 39'(QONE) + r11 - r00 - r22;
        qo[2] <= '0; qo[0] <= r02 - r20; qo[1] <= r01 + r10; qo[3] <= r12 + r21;
      end else begin
        mi <= 2'd3; vv <= 39'(QONE) + r22 - r00 - r11;
        qo[3] <= '0; qo[0] <= r10 - r01; qo[1] <= r02 + r20; qo[2] <= r12 + r21;
      end
    end
  end

  // Root of the branch value. A sum or difference of two elements can reach 2^31,
  // so each component travels with 33 bits.
  logic [65:0] vrad;
  logic [32:0] root;
  logic        vr;
  logic [131:0] qo_r;
  logic [1:0]   mi_r;
  assign vrad = vv[38] ? '0 : 66'({vv[35:0], 30'd0});
  smq_isqrt #(.IN_W(66), .TAG_W(134)) u_root (
    .clk, .rst, .en, .in_valid(vc), .radicand(vrad),
    .in_tag({mi, qo[0][32:0], qo[1][32:0], qo[2][32:0], qo[3][32:0]}),
    .out_valid(vr), .root(root), .out_tag({mi_r, qo_r}));

  logic signed [36:0] qc [4];
  logic [3:0] qv;
  logic [1:0] mi_q;
  logic [34:0] qt [4];
  for (genvar k = 0; k < 4; k++) begin : g_qdiv
    logic signed [32:0] a;
    logic [32:0] am;
    logic signed [36:0] qq;
    assign a  = qo_r[131-33*k -: 33];
    assign am = a[32] ? 33'(-a) : 33'(a);
    smq_div #(.NUM_W(33), .DEN_W(34), .Q_W(36), .TAG_W(35)) u_dv (
      .clk, .rst, .en, .in_valid(vr), .mag(am), .neg(a[32]),
      .den({root, 1'b0} == '0 ? 34'd1 : {root, 1'b0}),
      .in_tag({mi_r, root}), .out_valid(qv[k]), .quot(qq), .out_tag(qt[k]));
    assign qc[k] = (qt[k][34:33] == 2'(k)) ? 37'(qt[k][32:1]) : qq;
  end
  assign mi_q = qt[0][34:33];

  // Final length.
  logic [65:0] sq4 [4];
  logic [66:0] s4;
  logic        v4, v5;
  logic signed [36:0] qh [4];
  logic signed [36:0] qh2 [4];
  always_ff @(posedge clk) begin
    if (rst) begin v4 <= 1'b0; v5 <= 1'b0; end
    else if (en) begin v4 <= qv[0]; v5 <= v4; end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq4[k] <= 66'($signed(qc[k][32:0]) * $signed(qc[k][32:0]));
        qh[k]  <= qc[k];
        qh2[k] <= qh[k];
      end
      s4 <= 67'(sq4[0]) + 67'(sq4[1]) + 67'(sq4[2]) + 67'(sq4[3]);
    end
  end
  logic [33:0] len4;
  logic        vl;
  logic [131:0] qh_l;
  smq_isqrt #(.IN_W(67), .TAG_W(132)) u_len (
    .clk, .rst, .en, .in_valid(v5), .radicand(s4),
    .in_tag({qh2[0][32:0], qh2[1][32:0], qh2[2][32:0], qh2[3][32:0]}),
    .out_valid(vl), .root(len4), .out_tag(qh_l));

  logic [3:0] ov;
  logic signed [36:0] qf [4];
  logic pt [4];
  for (genvar k = 0; k < 4; k++) begin : g_ndiv
    logic signed [32:0] a;
    logic [32:0] am;
    logic signed [36:0] qq;
    logic [32:0] pas;
    assign a  = qh_l[131-33*k -: 33];
    assign am = a[32] ? 33'(-a) : 33'(a);
    smq_div #(.NUM_W(33), .DEN_W(34), .Q_W(36), .TAG_W(34)) u_dv (
      .clk, .rst, .en, .in_valid(vl), .mag(am), .neg(a[32]),
      .den(len4 == '0 ? 34'd1 : len4), .in_tag({len4 == '0, a}),
      .out_valid(ov[k]), .quot(qq), .out_tag({pt[k], pas}));
    assign qf[k] = pt[k] ? 37'($signed(pas)) : qq;
  end

  assign out_valid = ov[0];
  assign out_data.quat_w = qf[0][31:0];
  assign out_data.quat_x = qf[1][31:0];
  assign out_data.quat_y = qf[2][31:0];
  assign out_data.quat_z = qf[3][31:0];

  logic unused_ok;
  assign unused_ok = ^{raw_c[1], raw_c[2], sv[2:1], rv[8:1], qv[3:1], ov[3:1], mi_q,
                       FRAC_UNUSED[0]};

`ifndef SYNTHESIS
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_lane: assert property (@(posedge clk) disable iff (rst)
    ov[0] == ov[3]) else $error("component lanes out of step");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (qf[0] <= 37'sd1073741824 && qf[0] >= -37'sd1073741824))
    else $error("quaternion out of range");
`endif
endmodule

### test/quat_checker.sv
`timescale 1ns / 1ps

module quat_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  smq_pkg::smq_in_t    in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  smq_pkg::smq_out_t   out_data,
  output int                  fail_count,
  output int                  pending
);
  import smq_pkg::*;

  localparam logic [63:0] UNIT = 64'd1 << QBITS;

  smq_out_t quat_queue[$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] magnitude(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Scaled division, truncated toward zero.
  function automatic longint scaled_div(input longint num, input logic [63:0] den);
    logic [63:0] q;
    if (den == 0) den = 1;
    q = (magnitude(num) << QBITS) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void unit_column(input longint a, input longint b, input longint c,
                                      output longint ra, output longint rb,
                                      output longint rc);
    logic [63:0] len;
    len = floor_sqrt(magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b)
                     + magnitude(c) * magnitude(c));
    if (len < 1) len = 1;
    ra = scaled_div(a, len);
    rb = scaled_div(b, len);
    rc = scaled_div(c, len);
  endfunction

  function automatic smq_out_t matrix_to_quat(input smq_in_t m);
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
    longint tr, v;
    longint q[4];
    int main_idx;
    logic [63:0] root, len, s;
    smq_out_t res;
    unit_column(m.col0_x, m.col0_y, m.col0_z, r00, r10, r20);
    unit_column(m.col1_x, m.col1_y, m.col1_z, r01, r11, r21);
    unit_column(m.col2_x, m.col2_y, m.col2_z, r02, r12, r22);
    tr = r00 + r11 + r22;
    if (tr > 0) begin
      main_idx = 0;
      v = UNIT + tr;
      q[1] = r21 - r12; q[2] = r02 - r20; q[3] = r10 - r01;
    end else if (r00 > r11 && r00 > r22) begin
      main_idx = 1;
      v = UNIT + r00 - r11 - r22;
      q[0] = r21 - r12; q[2] = r01 + r10; q[3] = r02 + r20;
    end else if (r11 > r22) begin
      main_idx = 2;
      v = UNIT + r11 - r00 - r22;
      q[0] = r02 - r20; q[1] = r01 + r10; q[3] = r12 + r21;
    end else begin
      main_idx = 3;
      v = UNIT + r22 - r00 - r11;
      q[0] = r10 - r01; q[1] = r02 + r20; q[2] = r12 + r21;
    end
    if (v < 0) v = 0;
    root = floor_sqrt(v << QBITS);
    for (int k = 0; k < 4; k++) begin
      if (k == main_idx) q[k] = longint'(root >> 1);
      else q[k] = scaled_div(q[k], 2 * root);
    end
    s = 0;
    for (int k = 0; k < 4; k++) s = s + magnitude(q[k]) * magnitude(q[k]);
    len = floor_sqrt(s);
    if (len >= 1)
      for (int k = 0; k < 4; k++) q[k] = scaled_div(q[k], len);
    res.quat_w = q[0][31:0];
    res.quat_x = q[1][31:0];
    res.quat_y = q[2][31:0];
    res.quat_z = q[3][31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = quat_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    smq_out_t want;
    if (!rst) begin
      if (in_valid && !in_stall) quat_queue.push_back(matrix_to_quat(in_data));
      if (out_valid && !out_stall) begin
        if (quat_queue.size() == 0) begin
          report_mismatch("unexpected result", out_data.quat_w, 32'h0);
        end else begin
          want = quat_queue.pop_front();
          if (out_data.quat_w !== want.quat_w)
            report_mismatch("quat_w", out_data.quat_w, want.quat_w);
          if (out_data.quat_x !== want.quat_x)
            report_mismatch("quat_x", out_data.quat_x, want.quat_x);
          if (out_data.quat_y !== want.quat_y)
            report_mismatch("quat_y", out_data.quat_y, want.quat_y);
          if (out_data.quat_z !== want.quat_z)
            report_mismatch("quat_z", out_data.quat_z, want.quat_z);
        end
      end
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import smq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  smq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  smq_out_t out_data;
  int fail_count;
  int pending;
  bit hold_off = 1'b0;
  bit sending_done = 1'b0;

  always #10 clk = ~clk;

  scaled_matrix_to_quaternion uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  quat_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] random_element(input int style);
    case (style)
      0: return $urandom();
      1: return $signed($urandom_range(0, 131072)) - 32'sd65536;
      2: return $urandom_range(0, 3) == 0 ? 32'h0 : $signed($urandom_range(0, 511)) - 256;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return 32'h1;
        endcase
      end
    endcase
  endfunction

  // Styles 4 and 5 give one large entry per column at a shared row offset, plus noise,
  // so every branch of the conversion is reached.
  function automatic smq_in_t random_matrix();
    smq_in_t m;
    logic [31:0] e[9];
    int style;
    int perm;
    style = $urandom_range(0, 5);
    for (int i = 0; i < 9; i++) e[i] = random_element(style > 3 ? 1 : style);
    if (style > 3) begin
      perm = $urandom_range(0, 2);
      for (int c = 0; c < 3; c++)
        e[c * 3 + (c + perm) % 3] = ($urandom_range(0, 1) ? 1 : -1) *
                                    $signed($urandom_range(100000, 4000000));
    end
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  task automatic send_matrix(input smq_in_t m);
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_diag(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    send_matrix({a, 32'h0, 32'h0, 32'h0, b, 32'h0, 32'h0, 32'h0, c});
  endtask

  // Receiver: random stalls, with one long hold-off requested by the sender.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = gap_length();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    smq_in_t m;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity, half turns about each axis, zero matrix, tie on diagonal.
    send_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_diag(32'h0001_0000, 32'hffff_0000, 32'hffff_0000);
    send_diag(32'hffff_0000, 32'h0001_0000, 32'hffff_0000);
    send_diag(32'hffff_0000, 32'hffff_0000, 32'h0001_0000);
    send_diag(32'h0, 32'h0, 32'h0);
    send_diag(32'hffff_0000, 32'hffff_0000, 32'hffff_0000);
    send_diag(32'h0, 32'h0, 32'h0001_0000);
    send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_diag(32'h7fff_ffff, 32'h1, 32'h8000_0000);
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'h7fff_ffff}});
    send_matrix({9{32'hffff_ffff}});
    send_matrix({9{32'h1}});
    // Sheared and scaled: 90 degree turn about z with unequal column scale.
    send_matrix({32'h0, 32'h0003_0000, 32'h0, 32'hfff8_0000, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0000_8000});
    send_matrix({32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0001_0000, 32'h0001_0000,
                 32'h0, 32'h0, 32'h0, 32'h0001_0000});

    // Pause until every result has come back.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 650; i++) begin
      if (i == 200) hold_off = 1'b1;
      if (i == 450) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_matrix(random_matrix());
      if ($urandom_range(0, 3) == 0) idle_cycles(gap_length());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule
